/* hw/rtl/ted_pkg.sv */
// Package for the text encoding detector: encoding codes, byte constants
// and the transaction types that travel between the block's modules.
// No dependencies.
package ted_pkg;

	// Encoding codes given at the end of each string.
	localparam logic [1:0] ENC_EMPTY   = 2'd0;
	localparam logic [1:0] ENC_ANSI    = 2'd1;
	localparam logic [1:0] ENC_UTF16LE = 2'd2;
	localparam logic [1:0] ENC_UTF8    = 2'd3;

	// Byte-order mark bytes.
	localparam logic [7:0] BOM8_B0  = 8'hEF;
	localparam logic [7:0] BOM8_B1  = 8'hBB;
	localparam logic [7:0] BOM8_B2  = 8'hBF;
	localparam logic [7:0] BOM16_B0 = 8'hFF;
	localparam logic [7:0] BOM16_B1 = 8'hFE;

	// Top two bits of a continuation byte.
	localparam logic [1:0] CONT_TAG = 2'b10;

	// Byte position saturates at this value.
	localparam logic [1:0] POS_MAX = 2'd3;

	// One input transaction as held in the input register.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       empty_string;
	} item_t;

	// Per-string tracking state.
	typedef struct packed {
		logic [1:0] byte_position;
		logic       utf8_mark_possible;
		logic       utf16_mark_possible;
		logic [1:0] continuations_due;
		logic       saw_multibyte;
		logic       sequence_invalid;
	} track_t;

	localparam track_t TRACK_CLEAR = '{
		byte_position:       2'd0,
		utf8_mark_possible:  1'b1,
		utf16_mark_possible: 1'b1,
		continuations_due:   2'd0,
		saw_multibyte:       1'b0,
		sequence_invalid:    1'b0
	};

	// Handshake between the classifier and the output register.
	typedef struct packed {
		logic       load;
		logic [1:0] encoding;
	} result_ctl_t;

endpackage

/* hw/rtl/ted_in_if.sv */
// Byte channel of the text encoding detector: valid, ready and one byte
// with its end and empty marks. Depends on nothing.
interface ted_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       empty_string;

	modport source (output valid, output data_byte, output last_byte,
		output empty_string, input ready);
	modport sink (input valid, input data_byte, input last_byte,
		input empty_string, output ready);
endinterface

/* hw/rtl/ted_out_if.sv */
// Result channel of the text encoding detector: valid, ready and the
// two-bit encoding code. Depends on nothing.
interface ted_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] encoding;

	modport source (output valid, output encoding, input ready);
	modport sink (input valid, input encoding, output ready);
endinterface

/* hw/rtl/ted_input_stage.sv */
// Input register of the text encoding detector.
// Depends on ted_pkg and ted_in_if.
module ted_input_stage (
	input  logic            clk,
	input  logic            arst_n,
	ted_in_if.sink          bytes,
	input  logic            advance,
	output logic            valid_s1,
	output ted_pkg::item_t  item_s1
);
	import ted_pkg::*;

	logic accept;

	// A new transaction enters when the stage is empty or is moving on.
	assign bytes.ready = !valid_s1 || advance;
	assign accept      = bytes.valid && bytes.ready;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	// Payload register, loaded only on an accepted transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{
				data_byte:    bytes.data_byte,
				last_byte:    bytes.last_byte,
				empty_string: bytes.empty_string
			};
		end
	end

endmodule

/* hw/rtl/ted_classifier.sv */
// Per-string tracking state and the encoding decision for the detector.
// Depends on ted_pkg.
module ted_classifier (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  ted_pkg::item_t        item_s1,
	input  logic                  out_free,
	output logic                  advance,
	output ted_pkg::result_ctl_t  res
);
	import ted_pkg::*;

	track_t     trk_q;
	track_t     trk_n;
	logic [7:0] b;
	logic [1:0] pos;
	logic       ends;
	logic [1:0] code;

	assign b    = item_s1.data_byte;
	assign pos  = trk_q.byte_position;
	assign ends = item_s1.last_byte || item_s1.empty_string;

	// An item moves on unless it ends a string and the output is full.
	assign advance  = valid_s1 && (!ends || out_free);
	assign res.load = advance && ends;

	// Next tracking state for a non-empty byte.
	always_comb begin
		trk_n = trk_q;
		// Byte-order mark matching.
		unique case (pos)
			2'd0: begin
				trk_n.utf8_mark_possible  = trk_q.utf8_mark_possible && (b == BOM8_B0);
				trk_n.utf16_mark_possible = trk_q.utf16_mark_possible && (b == BOM16_B0);
			end
			2'd1: begin
				trk_n.utf8_mark_possible  = trk_q.utf8_mark_possible && (b == BOM8_B1);
				trk_n.utf16_mark_possible = trk_q.utf16_mark_possible && (b == BOM16_B1);
			end
			2'd2: begin
				trk_n.utf8_mark_possible = trk_q.utf8_mark_possible && (b == BOM8_B2);
			end
			default: begin
			end
		endcase
		if (pos != POS_MAX) begin
			trk_n.byte_position = pos + 2'd1;
		end
		// UTF-8 structure checking.
		if (trk_q.continuations_due != 2'd0) begin
			if (b[7:6] != CONT_TAG) begin
				trk_n.sequence_invalid = 1'b1;
			end
			trk_n.continuations_due = trk_q.continuations_due - 2'd1;
		end else if (b[7]) begin
			trk_n.saw_multibyte = 1'b1;
			priority casez (b[7:3])
				5'b110??: trk_n.continuations_due = 2'd1;
				5'b1110?: trk_n.continuations_due = 2'd2;
				5'b11110: trk_n.continuations_due = 2'd3;
				default:  trk_n.sequence_invalid  = 1'b1;
			endcase
		end
	end

	// Encoding decision at the end of a string.
	always_comb begin
		if (item_s1.empty_string) begin
			code = ENC_EMPTY;
		end else if (pos >= 2'd2 && trk_n.utf8_mark_possible) begin
			code = ENC_UTF8;
		end else if (pos >= 2'd1 && trk_n.utf16_mark_possible) begin
			code = ENC_UTF16LE;
		end else if (!trk_n.sequence_invalid && trk_n.continuations_due == 2'd0
				&& trk_n.saw_multibyte) begin
			code = ENC_UTF8;
		end else begin
			code = ENC_ANSI;
		end
	end

	assign res.encoding = code;

	// Tracking state: cleared at the end of every string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q <= TRACK_CLEAR;
		end else if (advance) begin
			if (ends) begin
				trk_q <= TRACK_CLEAR;
			end else begin
				trk_q <= trk_n;
			end
		end
	end

`ifndef ASSERT_OFF
	// The state is clean after a string has ended.
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |=> (trk_q == TRACK_CLEAR))
		else $error("tracking state not cleared after end of string");

	// An empty string always answers with the empty code.
	a_empty_code: assert property (@(posedge clk) disable iff (!arst_n)
		(res.load && item_s1.empty_string) |-> (res.encoding == ENC_EMPTY))
		else $error("empty string gave a non-empty code");

	// A result is only loaded from an occupied input stage.
	a_load_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |-> valid_s1)
		else $error("result loaded without an item");

	// A UTF-16 mark answer needs the first two bytes seen.
	a_utf16_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(res.load && res.encoding == ENC_UTF16LE) |-> (pos != 2'd0))
		else $error("UTF-16 code on a one-byte string");
`endif

endmodule

/* hw/rtl/ted_output_reg.sv */
// Result register of the text encoding detector, driving the result
// channel. Depends on ted_pkg and ted_out_if.
module ted_output_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ted_pkg::result_ctl_t  res,
	output logic                  out_free,
	ted_out_if.source             result
);
	import ted_pkg::*;

	logic       valid_q;
	logic [1:0] encoding_q;

	// Room for a new result when empty or being drained this cycle.
	assign out_free = !valid_q || result.ready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res.load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (res.load) begin
			encoding_q <= res.encoding;
		end
	end

	assign result.valid    = valid_q;
	assign result.encoding = encoding_q;

endmodule

/* hw/rtl/text_encoding_detector.sv */
// Text encoding detector: classifies each byte string as empty, ANSI,
// UTF-16LE or UTF-8 from its bytes, one byte per transaction.
// Usage:
//   bytes  - byte channel (valid/ready). Each transaction carries one byte
//            of the string in order, with last_byte set on its final byte.
//            A transaction with empty_string set stands for a zero-length
//            string, carries no byte and also drops any partial string.
//   result - result channel (valid/ready). One transaction per string,
//            carrying the two-bit encoding code: 0 empty, 1 ANSI,
//            2 UTF-16LE, 3 UTF-8.
//   Path: the transaction with the last byte (or the empty mark) is held
//   in the input register after the edge that accepts it, then loaded
//   into the result register once it has room, raising result.valid.
//   Throughput: one byte per cycle, but a string-ending byte waits while
//   the result register is full; the per-byte update is a single pass of
//   flag and counter logic between the input and result registers.
//   Reset: arst_n clears both valid flags and the tracking state, so the
//   next byte is taken as the first of a new string.
//   Stall: while the result register holds an untaken result, bytes that
//   do not end a string still flow; a string-ending byte waits in the
//   input register, and bytes.ready drops once that register is blocked.
// Depends on ted_pkg, ted_in_if, ted_out_if and the ted_* submodules.
module text_encoding_detector (
	input  logic      clk,
	input  logic      arst_n,
	ted_in_if.sink    bytes,
	ted_out_if.source result
);
	import ted_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic        advance;
	logic        out_free;
	result_ctl_t res;

	// Input register.
	ted_input_stage u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (bytes),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// String tracking and decision.
	ted_classifier u_classifier (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.advance  (advance),
		.res      (res)
	);

	// Result register.
	ted_output_reg u_output (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.out_free (out_free),
		.result   (result)
	);

endmodule
